[hw/rtl/c3s1_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// c3s1_pkg
// Types and constants shared by the 3x3 stride-1 convolution unit.
// ----------------------------------------------------------------------------
package c3s1_pkg;

  localparam int KDIM       = 3;
  localparam int FRAC_BITS  = 8;
  localparam int PROD_W     = 32;
  localparam int VAL_W      = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 6;

  localparam logic [1:0] KDIM_LAST = 2'd2;

  // config register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_IN_HEIGHT   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IN_WIDTH    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IN_CHANNELS = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PAD_TOP     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_LEFT_PAD    = 3'd4;

  typedef enum logic [1:0] {
    REQ_IMAGE   = 2'd0,
    REQ_WEIGHT  = 2'd1,
    REQ_BIAS    = 2'd2,
    REQ_COMPUTE = 2'd3
  } req_kind_t;

  typedef struct packed {
    req_kind_t          req_type;
    logic [4:0]         row;
    logic [4:0]         col;
    logic [3:0]         in_ch;
    logic [3:0]         out_ch;
    logic [1:0]         tap_row;
    logic [1:0]         tap_col;
    logic signed [15:0] value;
  } req_t;

  typedef struct packed {
    logic signed [15:0] out_value;
    logic               out_saturated;
  } res_t;

  typedef struct packed {
    logic [5:0] in_height;
    logic [5:0] in_width;
    logic [4:0] in_channels;
    logic [1:0] pad_top;
    logic [1:0] left_pad;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    in_height:   6'd32,
    in_width:    6'd32,
    in_channels: 5'd16,
    pad_top:     2'd1,
    left_pad:    2'd1
  };

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD,
    S_BIAS,
    S_INIT,
    S_TAP,
    S_MAC,
    S_DRAIN,
    S_ROUND
  } seq_state_t;

  typedef struct packed {
    logic init;
    logic issue;
  } mac_ctl_t;

  typedef struct packed {
    logic               busy;
    logic               saturated;
    logic signed [15:0] result;
  } mac_sts_t;

endpackage
`default_nettype wire

[hw/rtl/c3s1_ifs.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// c3s1 channel interfaces
// Valid/ready request and result channels of the convolution unit.
// ----------------------------------------------------------------------------
interface c3s1_req_if import c3s1_pkg::*; ();
  logic valid;
  logic ready;
  req_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface c3s1_res_if import c3s1_pkg::*; ();
  logic valid;
  logic ready;
  res_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

[hw/rtl/c3s1_store.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// c3s1_store
// Image, weight and bias memories: one write port, registered reads.
// ----------------------------------------------------------------------------
module c3s1_store import c3s1_pkg::*; #(
  parameter int MAX_HEIGHT = 32,
  parameter int MAX_WIDTH  = 32,
  parameter int MAX_IN_CH  = 16,
  parameter int MAX_OUT_CH = 16,
  parameter int IMG_AW     = 14,
  parameter int WGT_AW     = 12
) (
  input  logic               clk,
  input  logic               load,
  input  req_t               req_q,
  input  logic [IMG_AW-1:0]  img_rd_addr,
  input  logic [WGT_AW-1:0]  wgt_rd_addr,
  output logic signed [15:0] img_q,
  output logic signed [15:0] wgt_q,
  output logic signed [15:0] bias_q
);

  localparam int IMG_DEPTH = MAX_HEIGHT * MAX_WIDTH * MAX_IN_CH;
  localparam int WGT_DEPTH = MAX_OUT_CH * KDIM * KDIM * MAX_IN_CH;
  localparam int OC_AW     = (MAX_OUT_CH > 1) ? $clog2(MAX_OUT_CH) : 1;

  logic signed [15:0] img_mem  [IMG_DEPTH];
  logic signed [15:0] wgt_mem  [WGT_DEPTH];
  logic signed [15:0] bias_mem [MAX_OUT_CH];

  logic              img_we;
  logic              wgt_we;
  logic              bias_we;
  logic [IMG_AW-1:0] img_wr_addr;
  logic [WGT_AW-1:0] wgt_wr_addr;
  logic [OC_AW-1:0]  bias_addr;

  always_comb begin
    img_we  = load && (req_q.req_type == REQ_IMAGE)
              && (int'(req_q.row) < MAX_HEIGHT) && (int'(req_q.col) < MAX_WIDTH)
              && (int'(req_q.in_ch) < MAX_IN_CH);
    wgt_we  = load && (req_q.req_type == REQ_WEIGHT)
              && (int'(req_q.tap_row) < KDIM) && (int'(req_q.tap_col) < KDIM)
              && (int'(req_q.in_ch) < MAX_IN_CH) && (int'(req_q.out_ch) < MAX_OUT_CH);
    bias_we = load && (req_q.req_type == REQ_BIAS)
              && (int'(req_q.out_ch) < MAX_OUT_CH);
    img_wr_addr = IMG_AW'((int'(req_q.row) * MAX_WIDTH + int'(req_q.col)) * MAX_IN_CH
                          + int'(req_q.in_ch));
    wgt_wr_addr = WGT_AW'(((int'(req_q.out_ch) * KDIM + int'(req_q.tap_row)) * KDIM
                           + int'(req_q.tap_col)) * MAX_IN_CH + int'(req_q.in_ch));
    bias_addr   = OC_AW'(req_q.out_ch);
  end

  always_ff @(posedge clk) begin
    if (img_we) begin
      img_mem[img_wr_addr] <= req_q.value;
    end
    img_q <= img_mem[img_rd_addr];
  end

  always_ff @(posedge clk) begin
    if (wgt_we) begin
      wgt_mem[wgt_wr_addr] <= req_q.value;
    end
    wgt_q <= wgt_mem[wgt_rd_addr];
  end

  always_ff @(posedge clk) begin
    if (bias_we) begin
      bias_mem[bias_addr] <= req_q.value;
    end
    bias_q <= bias_mem[bias_addr];
  end

endmodule
`default_nettype wire

[hw/rtl/c3s1_mac.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// c3s1_mac
// Shared multiply-accumulate unit with Q8.8 rounding and saturation.
// ----------------------------------------------------------------------------
module c3s1_mac import c3s1_pkg::*; #(
  parameter int MAX_IN_CH = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  mac_ctl_t           ctl,
  input  logic signed [15:0] img_q,
  input  logic signed [15:0] wgt_q,
  input  logic signed [15:0] bias_q,
  output mac_sts_t           sts
);

  // worst case sum of nine taps times all channels, plus sign
  localparam int ACC_W = PROD_W + $clog2(KDIM * KDIM * MAX_IN_CH + 1) + 1;
  localparam int QW    = ACC_W - FRAC_BITS;

  logic                     p1;
  logic                     p2;
  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  acc;
  logic signed [ACC_W-1:0]  x;
  logic        [QW-1:0]     q;
  logic                     sat_hi;
  logic                     sat_lo;

  // p1: memory data valid, p2: product valid
  always_ff @(posedge clk) begin
    if (rst) begin
      p1 <= 1'b0;
      p2 <= 1'b0;
    end else begin
      p1 <= ctl.issue;
      p2 <= p1;
    end
  end

  always_ff @(posedge clk) begin
    if (p1) begin
      prod <= img_q * wgt_q;
    end
    if (ctl.init) begin
      acc <= {{(ACC_W - VAL_W - FRAC_BITS){bias_q[15]}}, bias_q, {FRAC_BITS{1'b0}}};
    end else if (p2) begin
      acc <= acc + {{(ACC_W - PROD_W){prod[PROD_W-1]}}, prod};
    end
  end

  // floor((acc + half) / 256), then clip to 16 bits
  always_comb begin
    x      = acc + ACC_W'(1 << (FRAC_BITS - 1));
    q      = x[ACC_W-1:FRAC_BITS];
    sat_hi = !q[QW-1] && (|q[QW-2:VAL_W-1]);
    sat_lo = q[QW-1] && !(&q[QW-2:VAL_W-1]);
    sts.busy      = p1 || p2;
    sts.saturated = sat_hi || sat_lo;
    if (sat_hi) begin
      sts.result = 16'sh7fff;
    end else if (sat_lo) begin
      sts.result = 16'sh8000;
    end else begin
      sts.result = q[VAL_W-1:0];
    end
  end

endmodule
`default_nettype wire

[hw/rtl/c3s1_seq.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// c3s1_seq
// Request sequencer: loads, tap/channel walk for compute, result register.
// ----------------------------------------------------------------------------
module c3s1_seq import c3s1_pkg::*; #(
  parameter int MAX_HEIGHT = 32,
  parameter int MAX_WIDTH  = 32,
  parameter int MAX_IN_CH  = 16,
  parameter int MAX_OUT_CH = 16,
  parameter int IMG_AW     = 14,
  parameter int WGT_AW     = 12
) (
  input  logic              clk,
  input  logic              rst,
  input  cfg_t              cfg,
  c3s1_req_if.sink          req,
  c3s1_res_if.source        rsp,
  output logic              store_load,
  output req_t              req_q,
  output logic [IMG_AW-1:0] img_rd_addr,
  output logic [WGT_AW-1:0] wgt_rd_addr,
  output mac_ctl_t          mac_ctl,
  input  mac_sts_t          mac_sts
);

  localparam int IC_CW = $clog2(MAX_IN_CH + 1);

  seq_state_t        state;
  seq_state_t        state_next;
  logic [1:0]        kh;
  logic [1:0]        kw;
  logic [IC_CW-1:0]  ch;
  logic [IMG_AW-1:0] img_base;
  logic [WGT_AW-1:0] wgt_base;

  logic [8:0]        h_eff;
  logic [8:0]        w_eff;
  logic [IC_CW-1:0]  nc_eff;
  logic [8:0]        ih_p;
  logic [8:0]        iw_p;
  logic [8:0]        ih;
  logic [8:0]        iw;
  logic              tap_ok;
  logic              tap_last;
  logic              ch_last;
  logic              oc_bad;
  logic              accept;
  logic              res_load;

  always_comb begin
    h_eff  = (int'(cfg.in_height) > MAX_HEIGHT) ? 9'(MAX_HEIGHT) : 9'(cfg.in_height);
    w_eff  = (int'(cfg.in_width) > MAX_WIDTH) ? 9'(MAX_WIDTH) : 9'(cfg.in_width);
    nc_eff = (int'(cfg.in_channels) > MAX_IN_CH) ? IC_CW'(MAX_IN_CH)
                                                  : IC_CW'(cfg.in_channels);
    // positions before padding is taken off, so no negative values arise
    ih_p   = 9'(req_q.row) + 9'(kh);
    iw_p   = 9'(req_q.col) + 9'(kw);
    ih     = ih_p - 9'(cfg.pad_top);
    iw     = iw_p - 9'(cfg.left_pad);
    tap_ok = (ih_p >= 9'(cfg.pad_top)) && (ih < h_eff)
             && (iw_p >= 9'(cfg.left_pad)) && (iw < w_eff)
             && (nc_eff != '0);
    tap_last = (kh == KDIM_LAST) && (kw == KDIM_LAST);
    ch_last  = (ch == nc_eff - IC_CW'(1));
    oc_bad   = int'(req_q.out_ch) >= MAX_OUT_CH;
    img_rd_addr = img_base + IMG_AW'(ch);
    wgt_rd_addr = wgt_base + WGT_AW'(ch);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next    = state;
    req.ready     = 1'b0;
    store_load    = 1'b0;
    mac_ctl.init  = 1'b0;
    mac_ctl.issue = 1'b0;
    res_load      = 1'b0;
    unique case (state)
      S_IDLE: begin
        req.ready = 1'b1;
        if (req.valid) begin
          state_next = (req.data.req_type == REQ_COMPUTE) ? S_BIAS : S_LOAD;
        end
      end
      S_LOAD: begin
        store_load = 1'b1;
        state_next = S_IDLE;
      end
      S_BIAS: begin
        state_next = oc_bad ? S_ROUND : S_INIT;
      end
      S_INIT: begin
        mac_ctl.init = 1'b1;
        state_next   = S_TAP;
      end
      S_TAP: begin
        if (tap_ok) begin
          state_next = S_MAC;
        end else if (tap_last) begin
          state_next = S_DRAIN;
        end
      end
      S_MAC: begin
        mac_ctl.issue = 1'b1;
        if (ch_last) begin
          state_next = tap_last ? S_DRAIN : S_TAP;
        end
      end
      S_DRAIN: begin
        if (!mac_sts.busy) begin
          state_next = S_ROUND;
        end
      end
      S_ROUND: begin
        // hold the result until the output register is free
        if (!rsp.valid || rsp.ready) begin
          res_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign accept = req.valid && req.ready;

  always_ff @(posedge clk) begin
    if (accept) begin
      req_q <= req.data;
    end
    if (state == S_INIT) begin
      kh <= '0;
      kw <= '0;
    end else if ((state == S_TAP && !tap_ok) || (state == S_MAC && ch_last)) begin
      kw <= (kw == KDIM_LAST) ? 2'd0 : kw + 2'd1;
      kh <= (kw == KDIM_LAST) ? kh + 2'd1 : kh;
    end
    if (state == S_TAP) begin
      ch       <= '0;
      img_base <= IMG_AW'((int'(ih) * MAX_WIDTH + int'(iw)) * MAX_IN_CH);
      wgt_base <= WGT_AW'(((int'(req_q.out_ch) * KDIM + int'(kh)) * KDIM + int'(kw))
                          * MAX_IN_CH);
    end else if (state == S_MAC) begin
      ch <= ch + IC_CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (res_load) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      if (oc_bad) begin
        rsp.data <= '0;
      end else begin
        rsp.data.out_value     <= mac_sts.result;
        rsp.data.out_saturated <= mac_sts.saturated;
      end
    end
  end

endmodule
`default_nettype wire

[hw/rtl/conv3x3_stride1_padded_unit.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// conv3x3_stride1_padded_unit
// Direct 3x3 stride-1 padded convolution over a channels-last image store.
// ----------------------------------------------------------------------------
// Usage:
//   req  : valid/ready request channel. A word is a load (image element,
//          weight or bias) or a compute request for one output element.
//   rsp  : valid/ready result channel, one word per compute request.
//   cfg  : write-only port (cfg_we, cfg_index, cfg_data) for image height,
//          width, input channel count and top/left padding; write while idle.
// Timing:
//   A load writes the registered request word into the store. A compute
//   request walks the taps inside the image, every input channel of each,
//   then waits for the multiplier to drain and registers the rounded result.
//   One shared multiplier does one product a cycle while walking a tap's
//   channels; it sets the rate. The block takes one request at a time;
//   req.ready is high only when idle.
// Reset: returns to idle, drops rsp.valid, loads default configuration.
//   Store contents are not cleared and must be loaded before use.
// Stall: a finished result waits in the output register; the next request
//   is still taken, and a later result waits until that register is free.
module conv3x3_stride1_padded_unit import c3s1_pkg::*; #(
  parameter int MAX_HEIGHT = 32,
  parameter int MAX_WIDTH  = 32,
  parameter int MAX_IN_CH  = 16,
  parameter int MAX_OUT_CH = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  c3s1_req_if.sink              req,
  c3s1_res_if.source            rsp
);

  localparam int IMG_AW = $clog2(MAX_HEIGHT * MAX_WIDTH * MAX_IN_CH);
  localparam int WGT_AW = $clog2(MAX_OUT_CH * KDIM * KDIM * MAX_IN_CH);

  cfg_t               cfg;
  logic               store_load;
  req_t               req_q;
  logic [IMG_AW-1:0]  img_rd_addr;
  logic [WGT_AW-1:0]  wgt_rd_addr;
  logic signed [15:0] img_q;
  logic signed [15:0] wgt_q;
  logic signed [15:0] bias_q;
  mac_ctl_t           mac_ctl;
  mac_sts_t           mac_sts;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= CFG_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_IN_HEIGHT:   cfg.in_height   <= cfg_data;
        CFG_IN_WIDTH:    cfg.in_width    <= cfg_data;
        CFG_IN_CHANNELS: cfg.in_channels <= cfg_data[4:0];
        CFG_PAD_TOP:     cfg.pad_top     <= cfg_data[1:0];
        CFG_LEFT_PAD:    cfg.left_pad    <= cfg_data[1:0];
        default: begin
        end
      endcase
    end
  end

  c3s1_seq #(
    .MAX_HEIGHT (MAX_HEIGHT),
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_IN_CH  (MAX_IN_CH),
    .MAX_OUT_CH (MAX_OUT_CH),
    .IMG_AW     (IMG_AW),
    .WGT_AW     (WGT_AW)
  ) u_seq (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .req         (req),
    .rsp         (rsp),
    .store_load  (store_load),
    .req_q       (req_q),
    .img_rd_addr (img_rd_addr),
    .wgt_rd_addr (wgt_rd_addr),
    .mac_ctl     (mac_ctl),
    .mac_sts     (mac_sts)
  );

  c3s1_store #(
    .MAX_HEIGHT (MAX_HEIGHT),
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_IN_CH  (MAX_IN_CH),
    .MAX_OUT_CH (MAX_OUT_CH),
    .IMG_AW     (IMG_AW),
    .WGT_AW     (WGT_AW)
  ) u_store (
    .clk         (clk),
    .load        (store_load),
    .req_q       (req_q),
    .img_rd_addr (img_rd_addr),
    .wgt_rd_addr (wgt_rd_addr),
    .img_q       (img_q),
    .wgt_q       (wgt_q),
    .bias_q      (bias_q)
  );

  c3s1_mac #(
    .MAX_IN_CH (MAX_IN_CH)
  ) u_mac (
    .clk    (clk),
    .rst    (rst),
    .ctl    (mac_ctl),
    .img_q  (img_q),
    .wgt_q  (wgt_q),
    .bias_q (bias_q),
    .sts    (mac_sts)
  );

endmodule
`default_nettype wire

[hw/rtl/c3s1_chk.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// c3s1_chk
// Port-level checks of the convolution unit, bound to the top level.
// ----------------------------------------------------------------------------
module c3s1_chk import c3s1_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        req_valid,
  input logic        req_ready,
  input req_kind_t   req_type,
  input logic        rsp_valid,
  input logic        rsp_ready,
  input logic [15:0] rsp_value,
  input logic        rsp_sat
);

  // one request in flight: never ready right after taking a word
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) |=> !req_ready)
    else $error("request taken while previous one in flight");

  // loads produce no result
  a_load_no_result: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready && req_type != REQ_COMPUTE) |=> !$rose(rsp_valid))
    else $error("result appeared after a load");

  // a clipped result sits at a range limit
  a_sat_limit: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp_sat) |-> (rsp_value == 16'h7fff || rsp_value == 16'h8000))
    else $error("saturated result not at a limit");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_value)))
    else $error("stalled result word changed");

endmodule

bind conv3x3_stride1_padded_unit c3s1_chk u_chk (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req.valid),
  .req_ready (req.ready),
  .req_type  (req.data.req_type),
  .rsp_valid (rsp.valid),
  .rsp_ready (rsp.ready),
  .rsp_value (rsp.data.out_value),
  .rsp_sat   (rsp.data.out_saturated)
);
`default_nettype wire

[bench/conv3x3_stride1_padded_unit_test.sv]
// ----------------------------------------------------------------------------
// conv3x3_stride1_padded_unit_test
// Self-checking bench for the 3x3 stride-1 padded convolution unit. Loads
// and compute requests go in over the request channel. A predictor keeps its
// own image, weight and bias stores and the shape settings, and gives the
// rounded, saturated sum for each compute word. Each result word is checked
// against that in order. Idle bursts come on both channels, and one long
// receiver hold-off backs up the unit.
// ----------------------------------------------------------------------------
module conv3x3_stride1_padded_unit_test;
  import c3s1_pkg::*;

  localparam int H_MAX        = 32;
  localparam int W_MAX        = 32;
  localparam int C_MAX        = 16;
  localparam int OC_MAX       = 16;
  localparam int IMG_WORDS    = H_MAX * W_MAX * C_MAX;
  localparam int WGT_WORDS    = OC_MAX * KDIM * KDIM * C_MAX;
  localparam int TARGET_WORDS = 1950;
  localparam int QUIET_WORDS  = 300;
  localparam int CYCLE_LIMIT  = 2_000_000;
  localparam int DRAIN_CYCLES = 24;
  localparam int HOLD_CYCLES  = 700;
  localparam int GAP_MAX      = 18;

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  c3s1_req_if req_if();
  c3s1_res_if rsp_if();

  conv3x3_stride1_padded_unit dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req       (req_if),
    .rsp       (rsp_if)
  );

  always #6 clk = ~clk;

  // predictor state
  logic signed [15:0] img_mem  [IMG_WORDS];
  logic signed [15:0] wgt_mem  [WGT_WORDS];
  logic signed [15:0] bias_mem [OC_MAX];
  bit img_set  [IMG_WORDS];
  bit wgt_set  [WGT_WORDS];
  bit bias_set [OC_MAX];
  cfg_t shape;

  res_t conv_results_due[$];
  res_t due_word;

  int words_sent    = 0;
  int computes_sent = 0;
  int clipped_due   = 0;
  int results_seen  = 0;
  int mismatches    = 0;
  int shapes_used   = 0;
  int cycles        = 0;
  int stall_left    = 0;
  bit gaps_on       = 1'b1;
  bit hold_request  = 1'b0;
  bit rx_hold       = 1'b0;

  function automatic int img_index(int r, int c, int ch);
    return (r * W_MAX + c) * C_MAX + ch;
  endfunction

  function automatic int wgt_index(int oc, int kr, int kc, int ch);
    return ((oc * KDIM + kr) * KDIM + kc) * C_MAX + ch;
  endfunction

  function automatic int eff_h();
    return (int'(shape.in_height) > H_MAX) ? H_MAX : int'(shape.in_height);
  endfunction

  function automatic int eff_w();
    return (int'(shape.in_width) > W_MAX) ? W_MAX : int'(shape.in_width);
  endfunction

  function automatic int eff_c();
    return (int'(shape.in_channels) > C_MAX) ? C_MAX : int'(shape.in_channels);
  endfunction

  function automatic res_t conv_point(req_t r);
    res_t   res;
    longint acc;
    longint q;
    int     ih;
    int     iw;
    acc = longint'(bias_mem[r.out_ch]) * 256;
    for (int kr = 0; kr < KDIM; kr++) begin
      ih = int'(r.row) - int'(shape.pad_top) + kr;
      if (ih >= 0 && ih < eff_h()) begin
        for (int kc = 0; kc < KDIM; kc++) begin
          iw = int'(r.col) - int'(shape.left_pad) + kc;
          if (iw >= 0 && iw < eff_w()) begin
            for (int ch = 0; ch < eff_c(); ch++)
              acc += longint'(img_mem[img_index(ih, iw, ch)]) *
                     longint'(wgt_mem[wgt_index(r.out_ch, kr, kc, ch)]);
          end
        end
      end
    end
    // floor((acc + 128) / 256): nearest, ties go up
    q = (acc + 128) >>> FRAC_BITS;
    res.out_saturated = 1'b0;
    if (q > 32767) begin
      q = 32767;
      res.out_saturated = 1'b1;
    end else if (q < -32768) begin
      q = -32768;
      res.out_saturated = 1'b1;
    end
    res.out_value = q[15:0];
    return res;
  endfunction

  // update the stores or queue a result, at the edge the word is taken
  task automatic note_word(req_t w);
    res_t res;
    case (w.req_type)
      REQ_IMAGE: begin
        img_mem[img_index(w.row, w.col, w.in_ch)] = w.value;
        img_set[img_index(w.row, w.col, w.in_ch)] = 1'b1;
        words_sent++;
      end
      REQ_WEIGHT: begin
        // taps of 3 are dropped by the unit
        if (w.tap_row <= KDIM_LAST && w.tap_col <= KDIM_LAST) begin
          wgt_mem[wgt_index(w.out_ch, w.tap_row, w.tap_col, w.in_ch)] = w.value;
          wgt_set[wgt_index(w.out_ch, w.tap_row, w.tap_col, w.in_ch)] = 1'b1;
        end
        words_sent++;
      end
      REQ_BIAS: begin
        bias_mem[w.out_ch] = w.value;
        bias_set[w.out_ch] = 1'b1;
        words_sent++;
      end
      REQ_COMPUTE: begin
        res = conv_point(w);
        conv_results_due.push_back(res);
        computes_sent++;
        if (res.out_saturated) clipped_due++;
        words_sent++;
      end
    endcase
  endtask

  function automatic logic signed [15:0] pick_value();
    int v;
    case ($urandom_range(0, 9))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      2, 3, 4: return 16'($urandom);
      default: begin
        v = $urandom_range(0, 2048) - 1024;
        return v[15:0];
      end
    endcase
  endfunction

  function automatic req_t rand_word(req_kind_t k);
    logic [63:0] bits;
    req_t r;
    bits = {$urandom, $urandom};
    r = bits[$bits(req_t)-1:0];
    r.req_type = k;
    r.tap_row  = 2'($urandom_range(0, KDIM - 1));
    r.tap_col  = 2'($urandom_range(0, KDIM - 1));
    r.value    = pick_value();
    return r;
  endfunction

  task automatic send_word(req_t w);
    int gap;
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, GAP_MAX);
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_if.valid <= 1'b1;
    req_if.data  <= w;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    note_word(w);
  endtask

  task automatic load_image(int r, int c, int ch, logic signed [15:0] v);
    req_t w;
    w = rand_word(REQ_IMAGE);
    w.row   = 5'(r);
    w.col   = 5'(c);
    w.in_ch = 4'(ch);
    w.value = v;
    send_word(w);
  endtask

  task automatic load_weight(int oc, int kr, int kc, int ch, logic signed [15:0] v);
    req_t w;
    w = rand_word(REQ_WEIGHT);
    w.out_ch  = 4'(oc);
    w.tap_row = 2'(kr);
    w.tap_col = 2'(kc);
    w.in_ch   = 4'(ch);
    w.value   = v;
    send_word(w);
  endtask

  task automatic load_bias(int oc, logic signed [15:0] v);
    req_t w;
    w = rand_word(REQ_BIAS);
    w.out_ch = 4'(oc);
    w.value  = v;
    send_word(w);
  endtask

  // loads whatever this output still lacks, then asks for it
  task automatic compute_at(int r, int c, int oc);
    int ih;
    int iw;
    req_t w;
    if (!bias_set[oc]) load_bias(oc, pick_value());
    for (int kr = 0; kr < KDIM; kr++) begin
      ih = r - int'(shape.pad_top) + kr;
      for (int kc = 0; kc < KDIM; kc++) begin
        iw = c - int'(shape.left_pad) + kc;
        if (ih >= 0 && ih < eff_h() && iw >= 0 && iw < eff_w()) begin
          for (int ch = 0; ch < eff_c(); ch++) begin
            if (!img_set[img_index(ih, iw, ch)])
              load_image(ih, iw, ch, pick_value());
            if (!wgt_set[wgt_index(oc, kr, kc, ch)])
              load_weight(oc, kr, kc, ch, pick_value());
          end
        end
      end
    end
    w = rand_word(REQ_COMPUTE);
    w.row    = 5'(r);
    w.col    = 5'(c);
    w.out_ch = 4'(oc);
    send_word(w);
  endtask

  // all results in, plus time for a trailing load to finish
  task automatic settle();
    req_if.valid <= 1'b0;
    while (conv_results_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    @(posedge clk);
    case (idx)
      CFG_IN_HEIGHT:   shape.in_height   = d[5:0];
      CFG_IN_WIDTH:    shape.in_width    = d[5:0];
      CFG_IN_CHANNELS: shape.in_channels = d[4:0];
      CFG_PAD_TOP:     shape.pad_top     = d[1:0];
      CFG_LEFT_PAD:    shape.left_pad    = d[1:0];
      default: ;
    endcase
  endtask

  // spare upper data bits are random; the unit keeps only the field width
  task automatic set_shape(int h, int w, int c, int pt, int pl);
    settle();
    write_reg(CFG_IN_HEIGHT, 6'(h));
    write_reg(CFG_IN_WIDTH, 6'(w));
    write_reg(CFG_IN_CHANNELS, {1'($urandom), 5'(c)});
    write_reg(CFG_PAD_TOP, {4'($urandom), 2'(pt)});
    write_reg(CFG_LEFT_PAD, {4'($urandom), 2'(pl)});
    cfg_we <= 1'b0;
    shapes_used++;
  endtask

  // single tap: clipping both ways and rounding of half steps
  task automatic test_rounding_and_saturation();
    set_shape(1, 1, 1, 0, 0);
    load_image(0, 0, 0, 16'sh7FFF);
    load_weight(0, 0, 0, 0, 16'sh7FFF);
    load_bias(0, 16'sh7FFF);
    compute_at(0, 0, 0);
    load_weight(0, 0, 0, 0, 16'sh8000);
    compute_at(0, 0, 0);
    load_image(0, 0, 0, 16'sd1);
    load_bias(0, 16'sd0);
    load_weight(0, 0, 0, 0, 16'sd128);
    compute_at(0, 0, 0);
    load_weight(0, 0, 0, 0, -16'sd128);
    compute_at(0, 0, 0);
    load_weight(0, 0, 0, 0, -16'sd384);
    compute_at(0, 0, 0);
  endtask

  task automatic test_load_field_extremes();
    req_t w;
    load_image(31, 31, 15, 16'sh8000);
    load_weight(15, 2, 2, 15, 16'sh7FFF);
    load_bias(15, 16'sh8000);
    w = rand_word(REQ_WEIGHT);
    w.out_ch  = 4'd0;
    w.in_ch   = 4'd0;
    w.tap_row = 2'd3;
    w.tap_col = 2'd0;
    send_word(w);
    w.tap_row = 2'd0;
    w.tap_col = 2'd3;
    send_word(w);
    w.tap_row = 2'd3;
    w.tap_col = 2'd3;
    send_word(w);
    compute_at(0, 0, 0);
    // far outside a 1x1 image: bias only
    compute_at(31, 31, 15);
  endtask

  task automatic test_degenerate_shapes();
    set_shape(0, 1, 1, 0, 0);
    compute_at(0, 0, 0);
    compute_at(0, 0, 15);
    set_shape(1, 1, 0, 0, 0);
    load_bias(0, 16'sh7FFF);
    compute_at(0, 0, 0);
    set_shape(32, 32, 16, 1, 1);
    compute_at(0, 0, 3);
    compute_at(31, 31, 3);
    compute_at(15, 16, 3);
    // oversized settings clamp to the store limits; pad of 3 as given
    set_shape(63, 40, 31, 3, 3);
    compute_at(31, 31, 3);
    compute_at(2, 2, 3);
    set_shape(32, 32, 16, 0, 0);
    compute_at(31, 31, 3);
  endtask

  task automatic test_backpressure();
    set_shape(4, 4, 2, 1, 1);
    hold_request <= 1'b1;
    repeat (8)
      compute_at($urandom_range(0, 4), $urandom_range(0, 4), $urandom_range(0, 3));
    settle();
  endtask

  task automatic random_step();
    int hi_r;
    int hi_c;
    int r;
    int c;
    int oc;
    req_t w;
    case ($urandom_range(0, 19))
      0, 1, 2, 3, 4, 5, 6, 7, 8, 9: begin
        hi_r = eff_h() - 1 + int'(shape.pad_top);
        hi_c = eff_w() - 1 + int'(shape.left_pad);
        hi_r = (hi_r < 0) ? 0 : (hi_r > 31) ? 31 : hi_r;
        hi_c = (hi_c < 0) ? 0 : (hi_c > 31) ? 31 : hi_c;
        r  = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 31) : $urandom_range(0, hi_r);
        c  = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 31) : $urandom_range(0, hi_c);
        oc = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 3) : $urandom_range(0, 15);
        compute_at(r, c, oc);
      end
      10, 11, 12, 13, 14: begin
        if (eff_h() == 0 || eff_w() == 0 || eff_c() == 0)
          load_image($urandom, $urandom, $urandom, pick_value());
        else
          load_image($urandom_range(0, eff_h() - 1), $urandom_range(0, eff_w() - 1),
                     $urandom_range(0, eff_c() - 1), pick_value());
      end
      15, 16: load_weight($urandom, $urandom_range(0, 2), $urandom_range(0, 2), $urandom,
                          pick_value());
      17: load_bias($urandom, pick_value());
      18: begin
        w = rand_word(REQ_WEIGHT);
        if ($urandom_range(0, 1)) w.tap_row = 2'd3;
        else w.tap_col = 2'd3;
        send_word(w);
      end
      default: load_image($urandom, $urandom, $urandom, pick_value());
    endcase
  endtask

  task automatic test_random_mix();
    int stop_at;
    while (words_sent < TARGET_WORDS) begin
      if (TARGET_WORDS - words_sent < QUIET_WORDS) gaps_on <= 1'b0;
      case ($urandom_range(0, 9))
        0: set_shape($urandom_range(0, 3) == 0 ? 0 : $urandom_range(33, 63),
                     $urandom_range(0, 2), $urandom_range(0, 2) == 0 ? 0 : $urandom_range(17, 31),
                     $urandom_range(0, 3), $urandom_range(0, 3));
        1: set_shape(32, $urandom_range(1, 2), $urandom_range(1, 2),
                     $urandom_range(0, 3), $urandom_range(0, 3));
        default: set_shape($urandom_range(1, 8), $urandom_range(1, 8), $urandom_range(1, 4),
                           $urandom_range(0, 3), $urandom_range(0, 3));
      endcase
      stop_at = words_sent + $urandom_range(80, 200);
      if (stop_at > TARGET_WORDS) stop_at = TARGET_WORDS;
      while (words_sent < stop_at) random_step();
    end
  endtask

  // receiver: random stall bursts, plus the long hold when asked
  always @(posedge clk) begin
    if (rx_hold) begin
      rsp_if.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left   <= stall_left - 1;
      rsp_if.ready <= 1'b0;
    end else if (gaps_on && $urandom_range(0, 5) == 0) begin
      stall_left   <= $urandom_range(0, GAP_MAX - 1);
      rsp_if.ready <= 1'b0;
    end else begin
      rsp_if.ready <= 1'b1;
    end
  end

  initial begin
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request <= 1'b0;
        rx_hold      <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        rx_hold <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && rsp_if.valid && rsp_if.ready) begin
      results_seen++;
      if (conv_results_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result word %0d arrived with none due: value %0d sat %0b",
                   results_seen, rsp_if.data.out_value, rsp_if.data.out_saturated);
      end else begin
        due_word = conv_results_due.pop_front();
        if (rsp_if.data.out_value !== due_word.out_value ||
            rsp_if.data.out_saturated !== due_word.out_saturated) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result word %0d: got value %0d sat %0b, want value %0d sat %0b",
                     results_seen, rsp_if.data.out_value, rsp_if.data.out_saturated,
                     due_word.out_value, due_word.out_saturated);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still due", cycles,
               conv_results_due.size());
      $display("conv3x3_stride1_padded_unit regression: fail");
      $finish;
    end
  end

  initial begin
    rst           = 1'b1;
    cfg_we        = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    req_if.valid  = 1'b0;
    req_if.data   = '0;
    rsp_if.ready  = 1'b0;
    shape         = CFG_RESET;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    test_rounding_and_saturation();
    test_load_field_extremes();
    test_degenerate_shapes();
    test_backpressure();
    test_random_mix();
    settle();

    mismatches += conv_results_due.size();
    $display("%0d words taken, %0d results checked (%0d clipped) over %0d shape settings",
             words_sent, results_seen, clipped_due, shapes_used);
    $display("included one %0d-cycle result hold-off and a final stretch with no idling",
             HOLD_CYCLES);
    if (mismatches == 0)
      $display("conv3x3_stride1_padded_unit regression: pass");
    else
      $display("conv3x3_stride1_padded_unit regression: fail");
    $finish;
  end

endmodule
